// File: hw/rtl/reachable_subgraph_extract_top_macros.svh
// Assertion macros shared by the reachability block.
// Depends on i_clk and i_rst_n being present in the using module.
`ifndef REACHABLE_SUBGRAPH_EXTRACT_TOP_MACROS_SVH
`define REACHABLE_SUBGRAPH_EXTRACT_TOP_MACROS_SVH

// Checks that cond holds at every clock edge outside reset.
`define RSE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that ante implies cons in the following cycle.
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rse_pkg.sv
// Shared types and constants for the reachability block.
// No dependencies.
package rse_pkg;
    localparam int NODES = 32;
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    typedef struct packed {
        logic       action;
        logic [4:0] node_a;
        logic [4:0] node_b;
    } t_item;

    typedef struct packed {
        logic [4:0]  new_id;
        logic [4:0]  original_node;
        logic [31:0] neighbor_bits;
        logic [5:0]  node_count;
        logic [5:0]  dest_id;
        logic        dest_reachable;
        logic        last;
    } t_result;

    typedef struct packed {
        logic add_edge;
        logic init;
        logic pop;
        logic disc;
        logic load_row;
        logic bit_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic stack_empty;
        logic scan_empty;
        logic bit_done;
        logic last_node;
    } t_status;
endpackage

// File: hw/rtl/rse_ctrl.sv
// Controller state machine of the reachability block.
// Depends on rse_pkg.
module rse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_action,
    input  rse_pkg::t_status i_status,
    output rse_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    import rse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_POP, S_SCAN, S_ROW, S_BITS, S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_start && i_action) r_state <= S_POP;
                S_POP: r_state <= i_status.stack_empty ? S_ROW : S_SCAN;
                S_SCAN: if (i_status.scan_empty) r_state <= S_POP;
                S_ROW: r_state <= S_BITS;
                S_BITS: if (i_status.bit_done) r_state <= S_EMIT;
                S_EMIT: r_state <= i_status.last_node ? S_IDLE : S_ROW;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.add_edge = i_start && !i_action;
                o_cmd.init = i_start && i_action;
            end
            S_POP: o_cmd.pop = !i_status.stack_empty;
            S_SCAN: o_cmd.disc = !i_status.scan_empty;
            S_ROW: o_cmd.load_row = 1'b1;
            S_BITS: o_cmd.bit_step = 1'b1;
            S_EMIT: o_cmd.emit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: hw/rtl/rse_datapath.sv
// Datapath of the reachability block: adjacency matrix, walk stack,
// renumbering tables and result assembly. Depends on rse_pkg and the macros.
module rse_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rse_pkg::t_item   i_item,
    input  rse_pkg::t_cmd    i_cmd,
    output rse_pkg::t_status o_status,
    output logic             o_strobe,
    output rse_pkg::t_result o_result
);
    import rse_pkg::*;
    `include "reachable_subgraph_extract_top_macros.svh"

    logic [NODES-1:0] r_adj [NODES];
    logic [NODES-1:0] r_reached;
    logic [NW-1:0]    r_ren [NODES];
    logic [NW-1:0]    r_nor [NODES];
    logic [NW-1:0]    r_stack [NODES];
    logic [CW-1:0]    r_sp;
    logic [CW-1:0]    r_total;
    logic [NODES-1:0] r_scan;
    logic [NW-1:0]    r_v;
    logic [NODES-1:0] r_row;
    logic [NW-1:0]    r_j;
    logic [31:0]      r_bits;
    logic [CW-1:0]    r_k;
    logic [NW-1:0]    r_dest_b;
    logic             r_dest_ok;
    logic [CW-1:0]    r_dest_id;
    logic             r_strobe;
    t_result          r_out;
    logic [NW-1:0]    n_low;
    logic [NW-1:0]    n_disc_node;
    logic [NODES-1:0] n_bit_a;
    logic [NODES-1:0] n_bit_b;

    always_comb begin
        n_low = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_scan[i]) n_low = NW'(i);
        end
    end

    assign n_disc_node = i_cmd.init ? i_item.node_a : n_low;
    assign n_bit_a = {{(NODES-1){1'b0}}, 1'b1} << i_item.node_a;
    assign n_bit_b = {{(NODES-1){1'b0}}, 1'b1} << i_item.node_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) r_adj[i] <= '0;
            r_sp <= '0;
            r_total <= '0;
            r_k <= '0;
            r_strobe <= 1'b0;
            r_dest_ok <= 1'b0;
            r_reached <= '0;
            r_scan <= '0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.add_edge) begin
                for (int i = 0; i < NODES; i++) begin
                    if (NW'(i) == i_item.node_a || NW'(i) == i_item.node_b) begin
                        r_adj[i] <= r_adj[i]
                                  | ((NW'(i) == i_item.node_a) ? n_bit_b : '0)
                                  | ((NW'(i) == i_item.node_b) ? n_bit_a : '0);
                    end
                end
            end
            if (i_cmd.init || i_cmd.disc) begin
                if (i_cmd.init) begin
                    r_reached <= n_bit_a;
                    r_dest_b <= i_item.node_b;
                    r_dest_ok <= (i_item.node_a == i_item.node_b);
                    r_dest_id <= '0;
                    r_stack[0] <= i_item.node_a;
                    r_sp <= CW'(1);
                    r_total <= CW'(1);
                    r_k <= '0;
                end else begin
                    r_reached[n_low] <= 1'b1;
                    r_scan[n_low] <= 1'b0;
                    r_stack[r_sp[NW-1:0]] <= n_low;
                    r_sp <= r_sp + CW'(1);
                    r_total <= r_total + CW'(1);
                    if (n_low == r_dest_b) begin
                        r_dest_ok <= 1'b1;
                        r_dest_id <= r_total;
                    end
                end
                r_ren[n_disc_node] <= i_cmd.init ? '0 : r_total[NW-1:0];
                r_nor[i_cmd.init ? '0 : r_total[NW-1:0]] <= n_disc_node;
            end
            if (i_cmd.pop) begin
                r_sp <= r_sp - CW'(1);
                r_scan <= r_adj[r_stack[r_sp[NW-1:0] - NW'(1)]] & ~r_reached;
            end
            if (i_cmd.load_row) begin
                r_v <= r_nor[r_k[NW-1:0]];
                r_row <= r_adj[r_nor[r_k[NW-1:0]]];
                r_j <= '0;
                r_bits <= '0;
            end
            if (i_cmd.bit_step) begin
                if (r_row[r_j] && r_reached[r_j] && (r_j != r_v)) begin
                    r_bits[r_ren[r_j]] <= 1'b1;
                end
                r_j <= r_j + NW'(1);
            end
            if (i_cmd.emit) begin
                r_out <= '{
                    new_id: r_k[NW-1:0],
                    original_node: r_v,
                    neighbor_bits: r_bits,
                    node_count: r_total,
                    dest_id: r_dest_ok ? r_dest_id : r_total,
                    dest_reachable: r_dest_ok,
                    last: (r_k + CW'(1) == r_total)
                };
                r_k <= r_k + CW'(1);
            end
        end
    end

    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.scan_empty = (r_scan == '0);
    assign o_status.bit_done = (r_j == NW'(NODES - 1));
    assign o_status.last_node = (r_k + CW'(1) == r_total);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `RSE_ASSERT_ALWAYS(a_sp_le_total, r_sp <= r_total, "Stack deeper than reached count.")
    `RSE_ASSERT_ALWAYS(a_pop_nonempty, !i_cmd.pop || r_sp != '0, "Pop from an empty stack.")
    `RSE_ASSERT_NEXT(a_emit_strobe, i_cmd.emit, o_strobe && o_result.node_count != '0,
        "Emitted item lacks strobe or count.")
endmodule

// File: hw/rtl/reachable_subgraph_extract_top.sv
// Top level of the reachability block: joins the controller and datapath.
// Depends on rse_pkg, rse_ctrl and rse_datapath.
// An add-edge item is taken while idle and leaves busy low. A request walks the
// graph depth first: each stack pop is followed by a scan that records one newly
// discovered node per step, and a final empty pop ends the walk. It then builds
// each result by scanning one adjacency row bit by bit, so busy stays high from an
// accepted request until the last result is emitted. Results appear one per strobe
// and cannot be stalled; the last result of a request shows in the first cycle with
// busy low again, when the next item may already be accepted.
module reachable_subgraph_extract_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rse_pkg::t_item   i_item,
    output logic             o_strobe,
    output rse_pkg::t_result o_result
);
    import rse_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_action(i_item.action), .i_status(w_status),
        .o_cmd(w_cmd), .o_busy(busy)
    );

    rse_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_status(w_status), .o_strobe(o_strobe), .o_result(o_result)
    );
endmodule
